// ===== design/sierpinski_curve_segment_generator_top_macros.svh =====
// Assertion helpers shared by the curve generator modules.
`ifndef SIERPINSKI_CURVE_SEGMENT_GENERATOR_TOP_MACROS_SVH
`define SIERPINSKI_CURVE_SEGMENT_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SCSG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SCSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/scsg_pkg.sv =====
`default_nettype none

package scsg_pkg;

    localparam int MAX_ORDER = 8;
    localparam int LVL_W     = $clog2(MAX_ORDER + 1);
    localparam int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int ORDER_W   = 4;
    localparam int STEP_W    = 12;
    localparam int COORD_W   = 16;
    localparam int TOP_W     = 3;

    localparam logic [LVL_W-1:0]   MAX_LVL  = LVL_W'(MAX_ORDER);
    localparam logic [ORDER_W-1:0] MAX_ORD  = ORDER_W'(MAX_ORDER);
    localparam logic [TOP_W-1:0]   TOP_LAST = 3'd3;

    typedef enum logic [1:0] {
        CFG_ORDER   = 2'd0,
        CFG_STEP    = 2'd1,
        CFG_START_X = 2'd2,
        CFG_START_Y = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        KIND_A   = 3'd0,
        KIND_B   = 3'd1,
        KIND_C   = 3'd2,
        KIND_D   = 3'd3,
        KIND_TOP = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        DIR_SE = 3'd0,
        DIR_SW = 3'd1,
        DIR_NW = 3'd2,
        DIR_NE = 3'd3,
        DIR_E  = 3'd4,
        DIR_S  = 3'd5,
        DIR_W  = 3'd6,
        DIR_N  = 3'd7
    } dir_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] ph;
    } frame_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_DESC  = 6'b000100,
        ST_CLIMB = 6'b001000,
        ST_MOVE  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    typedef struct packed {
        logic start;
        logic push;
        logic pop;
        logic emit;
        logic write_seg;
        logic write_done;
    } cmd_t;

    typedef struct packed {
        logic finished;
        logic level_lt_ord;
        logic can_join;
        logic out_free;
    } sts_t;

    // Sub-curve drawn in slot ph of a curve of the given kind.
    function automatic logic [1:0] kid_kind(input kind_t kind, input logic [1:0] ph);
        logic [1:0] k;
        k = 2'd0;
        case (kind)
            KIND_A: begin
                case (ph)
                    2'd0: k = 2'd0;
                    2'd1: k = 2'd1;
                    2'd2: k = 2'd3;
                    default: k = 2'd0;
                endcase
            end
            KIND_B: begin
                case (ph)
                    2'd0: k = 2'd1;
                    2'd1: k = 2'd2;
                    2'd2: k = 2'd0;
                    default: k = 2'd1;
                endcase
            end
            KIND_C: begin
                case (ph)
                    2'd0: k = 2'd2;
                    2'd1: k = 2'd3;
                    2'd2: k = 2'd1;
                    default: k = 2'd2;
                endcase
            end
            KIND_D: begin
                case (ph)
                    2'd0: k = 2'd3;
                    2'd1: k = 2'd0;
                    2'd2: k = 2'd2;
                    default: k = 2'd3;
                endcase
            end
            KIND_TOP: k = ph;
            default:  k = 2'd0;
        endcase
        return k;
    endfunction

    // Joining segment after slot ph of a curve of the given kind.
    function automatic dir_t join_dir(input kind_t kind, input logic [1:0] ph);
        dir_t d;
        d = DIR_SE;
        case (kind)
            KIND_A: begin
                case (ph)
                    2'd0: d = DIR_SE;
                    2'd1: d = DIR_E;
                    2'd2: d = DIR_NE;
                    default: d = DIR_SE;
                endcase
            end
            KIND_B: begin
                case (ph)
                    2'd0: d = DIR_SW;
                    2'd1: d = DIR_S;
                    2'd2: d = DIR_SE;
                    default: d = DIR_SE;
                endcase
            end
            KIND_C: begin
                case (ph)
                    2'd0: d = DIR_NW;
                    2'd1: d = DIR_W;
                    2'd2: d = DIR_SW;
                    default: d = DIR_SE;
                endcase
            end
            KIND_D: begin
                case (ph)
                    2'd0: d = DIR_NE;
                    2'd1: d = DIR_N;
                    2'd2: d = DIR_NW;
                    default: d = DIR_SE;
                endcase
            end
            KIND_TOP: begin
                case (ph)
                    2'd0: d = DIR_SE;
                    2'd1: d = DIR_SW;
                    2'd2: d = DIR_NW;
                    default: d = DIR_NE;
                endcase
            end
            default: d = DIR_SE;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/scsg_ctrl.sv =====
`default_nettype none

`include "sierpinski_curve_segment_generator_top_macros.svh"

module scsg_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire scsg_pkg::sts_t sts,
    output scsg_pkg::cmd_t     cmd
);
    import scsg_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = sts.finished ? ST_DONE : ST_DESC;
            end
            ST_DESC: begin
                // one frame pushed per cycle until the order is reached
                if (sts.level_lt_ord) begin
                    cmd.push = 1'b1;
                end else begin
                    state_next = ST_CLIMB;
                end
            end
            ST_CLIMB: begin
                if (sts.can_join) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_MOVE;
                end else begin
                    cmd.pop = 1'b1;
                end
            end
            ST_MOVE: begin
                if (sts.out_free) begin
                    cmd.write_seg = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.write_done = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SCSG_ASSERT_NOW(a_push_below_order, cmd.push, sts.level_lt_ord, "push beyond curve order")
    `SCSG_ASSERT_NOW(a_write_slot_free, cmd.write_seg || cmd.write_done, sts.out_free,
        "result written over an untaken beat")

endmodule

`default_nettype wire

// ===== design/scsg_dp.sv =====
`default_nettype none

`include "sierpinski_curve_segment_generator_top_macros.svh"

module scsg_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [15:0]                       cfg_data,
    input  wire logic                              s_restart,
    input  wire scsg_pkg::cmd_t                    cmd,
    output scsg_pkg::sts_t                         sts,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [scsg_pkg::COORD_W-1:0]    m_from_x,
    output logic signed [scsg_pkg::COORD_W-1:0]    m_from_y,
    output logic signed [scsg_pkg::COORD_W-1:0]    m_to_x,
    output logic signed [scsg_pkg::COORD_W-1:0]    m_to_y,
    output logic                                   m_last_segment,
    output logic                                   m_done_res
);
    import scsg_pkg::*;

    // configuration
    logic [ORDER_W-1:0] order_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [COORD_W-1:0] start_x_reg;
    logic [COORD_W-1:0] start_y_reg;

    // walk state
    frame_t             stack_reg [MAX_ORDER];
    logic [LVL_W-1:0]   level_reg;
    logic [TOP_W-1:0]   top_reg;
    logic [COORD_W-1:0] pen_x_reg;
    logic [COORD_W-1:0] pen_y_reg;
    logic               finished_reg;
    dir_t               dir_reg;
    logic               last_pend_reg;

    // result beat
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [COORD_W-1:0] from_x_reg;
    logic [COORD_W-1:0] from_y_reg;
    logic [COORD_W-1:0] to_x_reg;
    logic [COORD_W-1:0] to_y_reg;
    logic               last_reg;
    logic               done_reg;

    logic [ORDER_W-1:0] ord_sat;
    logic [LVL_W-1:0]   level_dec;
    logic [IDX_W-1:0]   top_idx;
    logic [IDX_W-1:0]   push_idx;
    frame_t             top_frame;
    kind_t              parent_kind;
    logic [1:0]         parent_ph;
    logic [COORD_W-1:0] h1;
    logic [COORD_W-1:0] h2;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] pen_x_new;
    logic [COORD_W-1:0] pen_y_new;

    always_comb begin
        ord_sat     = (order_reg > MAX_ORD) ? MAX_ORD : order_reg;
        level_dec   = level_reg - LVL_W'(1);
        top_idx     = level_dec[IDX_W-1:0];
        push_idx    = level_reg[IDX_W-1:0];
        top_frame   = stack_reg[top_idx];
        if (level_reg == '0) begin
            parent_kind = KIND_TOP;
            parent_ph   = top_reg[1:0];
        end else begin
            parent_kind = kind_t'({1'b0, top_frame.kind});
            parent_ph   = top_frame.ph;
        end
    end

    always_comb begin
        sts.finished     = finished_reg;
        sts.level_lt_ord = level_reg < LVL_W'(ord_sat);
        sts.can_join     = (level_reg == '0) || (top_frame.ph != 2'd3);
        sts.out_free     = !m_valid_reg || m_ready;
    end

    // diagonals step h on both axes, axis segments 2h on one
    always_comb begin
        h1 = COORD_W'(step_reg);
        h2 = COORD_W'({step_reg, 1'b0});
        dx = '0;
        dy = '0;
        case (dir_reg)
            DIR_SE: begin dx = h1;      dy = h1;      end
            DIR_SW: begin dx = '0 - h1; dy = h1;      end
            DIR_NW: begin dx = '0 - h1; dy = '0 - h1; end
            DIR_NE: begin dx = h1;      dy = '0 - h1; end
            DIR_E:  begin dx = h2;      dy = '0;      end
            DIR_S:  begin dx = '0;      dy = h2;      end
            DIR_W:  begin dx = '0 - h2; dy = '0;      end
            DIR_N:  begin dx = '0;      dy = '0 - h2; end
            default: begin dx = '0;     dy = '0;      end
        endcase
        pen_x_new = pen_x_reg + dx;
        pen_y_new = pen_y_reg + dy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg   <= ORDER_W'(1);
            step_reg    <= STEP_W'(1);
            start_x_reg <= '0;
            start_y_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ORDER:   order_reg   <= cfg_data[ORDER_W-1:0];
                CFG_STEP:    step_reg    <= cfg_data[STEP_W-1:0];
                CFG_START_X: start_x_reg <= cfg_data;
                CFG_START_Y: start_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= '0;
            top_reg       <= '0;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            finished_reg  <= 1'b1;
            last_pend_reg <= 1'b0;
        end else begin
            if (cmd.start && s_restart) begin
                pen_x_reg    <= start_x_reg;
                pen_y_reg    <= start_y_reg;
                level_reg    <= '0;
                top_reg      <= '0;
                finished_reg <= 1'b0;
            end
            if (cmd.push) begin
                level_reg <= level_reg + LVL_W'(1);
            end
            if (cmd.pop) begin
                level_reg <= level_dec;
            end
            if (cmd.emit) begin
                if (level_reg == '0) begin
                    top_reg       <= top_reg + TOP_W'(1);
                    last_pend_reg <= top_reg == TOP_LAST;
                    if (top_reg == TOP_LAST) begin
                        finished_reg <= 1'b1;
                    end
                end else begin
                    last_pend_reg <= 1'b0;
                end
            end
            if (cmd.write_seg) begin
                pen_x_reg <= pen_x_new;
                pen_y_reg <= pen_y_new;
            end
            if (cmd.write_done) begin
                finished_reg <= 1'b1;
            end
        end
    end

    // frame stack and latched direction
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stack_reg[push_idx] <= '{kind: kid_kind(parent_kind, parent_ph), ph: 2'd0};
        end
        if (cmd.emit) begin
            dir_reg <= join_dir(parent_kind, parent_ph);
            if (level_reg != '0) begin
                stack_reg[top_idx] <= '{kind: top_frame.kind, ph: top_frame.ph + 2'd1};
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.write_seg || cmd.write_done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_seg) begin
            from_x_reg <= pen_x_reg;
            from_y_reg <= pen_y_reg;
            to_x_reg   <= pen_x_new;
            to_y_reg   <= pen_y_new;
            last_reg   <= last_pend_reg;
            done_reg   <= 1'b0;
        end else if (cmd.write_done) begin
            from_x_reg <= '0;
            from_y_reg <= '0;
            to_x_reg   <= '0;
            to_y_reg   <= '0;
            last_reg   <= 1'b0;
            done_reg   <= 1'b1;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_from_x       = $signed(from_x_reg);
    assign m_from_y       = $signed(from_y_reg);
    assign m_to_x         = $signed(to_x_reg);
    assign m_to_y         = $signed(to_y_reg);
    assign m_last_segment = last_reg;
    assign m_done_res     = done_reg;

    `SCSG_ASSERT_NOW(a_level_bound, 1'b1, level_reg <= MAX_LVL, "stack level past maximum order")
    `SCSG_ASSERT_NOW(a_top_end_finished, top_reg > TOP_LAST, finished_reg,
        "all diagonals drawn but pass not finished")
    `SCSG_ASSERT_NEXT(a_write_shows_beat, cmd.write_seg || cmd.write_done, m_valid_reg,
        "written result not presented")

endmodule

`default_nettype wire

// ===== design/sierpinski_curve_segment_generator_top.sv =====
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-----------------------------------------
// cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
// s        | in        | s_valid / s_ready      | s_restart
// m        | out       | m_valid / m_ready      | m_from_x/y, m_to_x/y, m_last_segment,
//          |           |                        | m_done_res
//
// A beat past the end of a pass goes through IDLE, CHECK and DONE. A segment goes through IDLE,
// CHECK, DESC, CLIMB and MOVE, one frame pushed or popped per cycle on the way; a segment
// either descends or climbs, never both, so it moves the frame stack by at most MAX_ORDER frames.
// A new beat is taken while the previous result still waits on m; a stalled m holds the
// walk before its write. cfg is always ready.
// aresetn (synchronous, active low) clears the walk and leaves the pass ended until restart.
`default_nettype none

module sierpinski_curve_segment_generator_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [15:0]                       cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_restart,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [scsg_pkg::COORD_W-1:0]    m_from_x,
    output logic signed [scsg_pkg::COORD_W-1:0]    m_from_y,
    output logic signed [scsg_pkg::COORD_W-1:0]    m_to_x,
    output logic signed [scsg_pkg::COORD_W-1:0]    m_to_y,
    output logic                                   m_last_segment,
    output logic                                   m_done_res
);
    import scsg_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    scsg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    scsg_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_restart      (s_restart),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_from_x       (m_from_x),
        .m_from_y       (m_from_y),
        .m_to_x         (m_to_x),
        .m_to_y         (m_to_y),
        .m_last_segment (m_last_segment),
        .m_done_res     (m_done_res)
    );

endmodule

`default_nettype wire

// ===== bench/sierpinski_curve_segment_generator_checker.sv =====
module sierpinski_curve_segment_generator_checker
    import scsg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_restart,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic signed [15:0] m_from_x,
    input  logic signed [15:0] m_from_y,
    input  logic signed [15:0] m_to_x,
    input  logic signed [15:0] m_to_y,
    input  logic              m_last_segment,
    input  logic              m_done_res,
    output int                fail_count,
    output int                outstanding
);

    typedef struct packed {
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
        logic               last;
        logic               done;
    } seg_t;

    // register copies
    logic [ORDER_W-1:0] order_r;
    logic [STEP_W-1:0]  step_r;
    logic [COORD_W-1:0] start_x_r;
    logic [COORD_W-1:0] start_y_r;

    // walk state
    kind_t              frame_kind [MAX_ORDER];
    logic [1:0]         frame_ph   [MAX_ORDER];
    logic [LVL_W-1:0]   lvl;
    logic [TOP_W-1:0]   top_pos;
    logic [COORD_W-1:0] pen_x;
    logic [COORD_W-1:0] pen_y;
    logic               ended;

    seg_t expected_segments [$];
    seg_t want;
    seg_t got;
    int   mismatches;

    function automatic kind_t kind_of(input logic [1:0] q);
        case (q)
            2'd0:    return KIND_A;
            2'd1:    return KIND_B;
            2'd2:    return KIND_C;
            default: return KIND_D;
        endcase
    endfunction

    function automatic dir_t diag_dir(input logic [1:0] q);
        case (q)
            2'd0:    return DIR_SE;
            2'd1:    return DIR_SW;
            2'd2:    return DIR_NW;
            default: return DIR_NE;
        endcase
    endfunction

    // Sub-curve that fills a slot: same kind at both ends, next kind before the axis,
    // previous kind before the closing diagonal.
    function automatic kind_t sub_kind(input kind_t parent, input logic [1:0] slot);
        logic [2:0] pk;
        pk = parent;
        if (parent == KIND_TOP) return kind_of(slot);
        case (slot)
            2'd1:    return kind_of(pk[1:0] + 2'd1);
            2'd2:    return kind_of(pk[1:0] - 2'd1);
            default: return kind_of(pk[1:0]);
        endcase
    endfunction

    function automatic dir_t joint_dir(input kind_t k, input logic [1:0] slot);
        logic [2:0] pk;
        pk = k;
        case (slot)
            2'd0: return diag_dir(pk[1:0]);
            2'd1: begin
                case (pk[1:0])
                    2'd0:    return DIR_E;
                    2'd1:    return DIR_S;
                    2'd2:    return DIR_W;
                    default: return DIR_N;
                endcase
            end
            default: return diag_dir(pk[1:0] - 2'd1);
        endcase
    endfunction

    function automatic int step_dx(input dir_t d);
        case (d)
            DIR_SE, DIR_NE: return 1;
            DIR_SW, DIR_NW: return -1;
            DIR_E:          return 2;
            DIR_W:          return -2;
            default:        return 0;
        endcase
    endfunction

    function automatic int step_dy(input dir_t d);
        case (d)
            DIR_SE, DIR_SW: return 1;
            DIR_NW, DIR_NE: return -1;
            DIR_S:          return 2;
            DIR_N:          return -2;
            default:        return 0;
        endcase
    endfunction

    function automatic seg_t next_segment(input logic restart);
        seg_t               seg;
        logic [ORDER_W-1:0] eff_order;
        kind_t              parent;
        logic [1:0]         slot;
        dir_t               d;
        logic               found;
        int                 stepv;
        int                 v;
        seg = '0;
        d = DIR_SE;
        if (restart) begin
            pen_x   = start_x_r;
            pen_y   = start_y_r;
            lvl     = '0;
            top_pos = '0;
            ended   = 1'b0;
        end
        if (ended || top_pos > TOP_LAST) begin
            ended    = 1'b1;
            seg.done = 1'b1;
            return seg;
        end
        eff_order = (order_r > MAX_ORD) ? MAX_ORD : order_r;
        // descend into the sub-curve after the previous segment
        while (lvl < eff_order) begin
            if (lvl == 0) begin
                parent = KIND_TOP;
                slot   = top_pos[1:0];
            end else begin
                parent = frame_kind[lvl-1];
                slot   = frame_ph[lvl-1];
            end
            frame_kind[lvl] = sub_kind(parent, slot);
            frame_ph[lvl]   = 2'd0;
            lvl = lvl + 1'b1;
        end
        // climb to the first frame with a joint left to draw
        found = 1'b0;
        while (!found) begin
            if (lvl == 0) begin
                d = diag_dir(top_pos[1:0]);
                top_pos = top_pos + 1'b1;
                if (top_pos > TOP_LAST) begin
                    seg.last = 1'b1;
                    ended    = 1'b1;
                end
                found = 1'b1;
            end else if (frame_ph[lvl-1] < 2'd3) begin
                d = joint_dir(frame_kind[lvl-1], frame_ph[lvl-1]);
                frame_ph[lvl-1] = frame_ph[lvl-1] + 2'd1;
                found = 1'b1;
            end else begin
                lvl = lvl - 1'b1;
            end
        end
        stepv = int'(step_r);
        seg.from_x = pen_x;
        seg.from_y = pen_y;
        v = step_dx(d) * stepv;
        pen_x = pen_x + v[15:0];
        v = step_dy(d) * stepv;
        pen_y = pen_y + v[15:0];
        seg.to_x = pen_x;
        seg.to_y = pen_y;
        return seg;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            order_r    = 4'd1;
            step_r     = 12'd1;
            start_x_r  = '0;
            start_y_r  = '0;
            lvl        = '0;
            top_pos    = '0;
            pen_x      = '0;
            pen_y      = '0;
            ended      = 1'b1;
            mismatches = 0;
            expected_segments.delete();
        end else begin
            // check the result beat before queueing a new prediction
            if (m_valid && m_ready) begin
                got.from_x = m_from_x;
                got.from_y = m_from_y;
                got.to_x   = m_to_x;
                got.to_y   = m_to_y;
                got.last   = m_last_segment;
                got.done   = m_done_res;
                if (expected_segments.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result beat: from=(%0d,%0d) to=(%0d,%0d) last=%0b done=%0b",
                                 m_from_x, m_from_y, m_to_x, m_to_y, m_last_segment, m_done_res);
                    mismatches++;
                end else begin
                    want = expected_segments.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("mismatch: expected from=(%0d,%0d) to=(%0d,%0d) last=%0b done=%0b",
                                     $signed(want.from_x), $signed(want.from_y),
                                     $signed(want.to_x), $signed(want.to_y), want.last, want.done);
                            $display("          actual   from=(%0d,%0d) to=(%0d,%0d) last=%0b done=%0b",
                                     m_from_x, m_from_y, m_to_x, m_to_y, m_last_segment, m_done_res);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_segments.push_back(next_segment(s_restart));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ORDER:   order_r   = cfg_data[ORDER_W-1:0];
                    CFG_STEP:    step_r    = cfg_data[STEP_W-1:0];
                    CFG_START_X: start_x_r = cfg_data;
                    CFG_START_Y: start_y_r = cfg_data;
                    default: ;
                endcase
            end
        end
        fail_count  <= mismatches;
        outstanding <= expected_segments.size();
    end

endmodule

// ===== bench/sierpinski_curve_segment_generator_top_tb.sv =====
module sierpinski_curve_segment_generator_top_tb;
    import scsg_pkg::*;

    localparam int ITEM_TARGET = 1100;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 80;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data  = 16'd0;
    logic        s_valid   = 1'b0;
    logic        s_restart = 1'b0;
    logic        m_ready   = 1'b0;

    wire logic        cfg_ready;
    wire logic        s_ready;
    wire logic        m_valid;
    wire logic signed [COORD_W-1:0] m_from_x;
    wire logic signed [COORD_W-1:0] m_from_y;
    wire logic signed [COORD_W-1:0] m_to_x;
    wire logic signed [COORD_W-1:0] m_to_y;
    wire logic        m_last_segment;
    wire logic        m_done_res;

    int fail_count;
    int outstanding;

    int items_sent;
    int send_calm_left;
    logic send_calm;
    int quiet_cycles;

    int   ord;
    int   len;
    int   mode;
    logic [3:0] ord4;

    always #4 aclk = ~aclk;

    sierpinski_curve_segment_generator_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_from_x       (m_from_x),
        .m_from_y       (m_from_y),
        .m_to_x         (m_to_x),
        .m_to_y         (m_to_y),
        .m_last_segment (m_last_segment),
        .m_done_res     (m_done_res)
    );

    sierpinski_curve_segment_generator_checker segment_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_from_x       (m_from_x),
        .m_from_y       (m_from_y),
        .m_to_x         (m_to_x),
        .m_to_y         (m_to_y),
        .m_last_segment (m_last_segment),
        .m_done_res     (m_done_res),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Upper bits of the narrow registers carry junk; the block must drop them.
    task automatic configure(input logic [3:0] order, input logic [11:0] step,
                             input logic [15:0] sx, input logic [15:0] sy);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(CFG_ORDER, {junk[15:4], order});
        write_reg(CFG_STEP, {junk[3:0], step});
        write_reg(CFG_START_X, sx);
        write_reg(CFG_START_Y, sy);
        cfg_valid <= 1'b0;
    endtask

    task automatic offer_item(input logic r);
        int gap;
        if (send_calm_left == 0) begin
            send_calm      = ($urandom_range(0, 2) == 0);
            send_calm_left = $urandom_range(20, 60);
        end
        send_calm_left--;
        gap = send_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= r;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Hold the input off until every predicted beat has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    function automatic logic [11:0] pick_step();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'hfff;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random stalls, calm stretches, one long hold-off
    initial begin : receiver
        int results_seen;
        int gap;
        int calm_left;
        logic calm;
        results_seen = 0;
        calm_left    = 0;
        calm         = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(20, 60);
            end
            calm_left--;
            gap = calm ? 0 : $urandom_range(0, 5);
            if (results_seen == HOLD_AT) gap = HOLD_CYCLES;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        items_sent     = 0;
        send_calm_left = 0;
        send_calm      = 1'b0;
        quiet_cycles   = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // out of reset the pass has ended: a plain beat gives done
        offer_item(1'b0);
        wait_for_results();

        // order zero: the four diagonals alone, then done; coordinates wrap
        configure(4'd0, 12'hfff, 16'h7fff, 16'h8000);
        offer_item(1'b1);
        repeat (4) offer_item(1'b0);
        wait_for_results();

        // full order-one pass up to the closing diagonal
        configure(4'd1, 12'd2048, 16'h8000, 16'h7fff);
        offer_item(1'b1);
        repeat (15) offer_item(1'b0);
        wait_for_results();

        // order above the maximum saturates
        configure(4'd15, 12'd0, 16'd0, 16'd0);
        offer_item(1'b1);
        repeat (2) offer_item(1'b0);
        wait_for_results();

        // change order and step mid-pass, carry on without restart
        configure(4'd2, 12'hfff, 16'h1234, 16'h4321);
        repeat (2) offer_item(1'b0);
        wait_for_results();

        // long order-three pass; the receiver hold-off lands in here
        configure(4'd3, pick_step(), pick_coord(), pick_coord());
        offer_item(1'b1);
        repeat (258) offer_item(1'b0);

        while (items_sent < ITEM_TARGET) begin
            wait_for_results();
            case ($urandom_range(0, 19))
                0:                 ord = 0;
                1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: ord = $urandom_range(1, 2);
                12, 13, 14:        ord = 3;
                15, 16, 17:        ord = $urandom_range(4, 8);
                default:           ord = $urandom_range(9, 15);
            endcase
            ord4 = 4'(ord);
            configure(ord4, pick_step(), pick_coord(), pick_coord());
            if (ord > MAX_ORDER) ord = MAX_ORDER;
            mode = $urandom_range(0, 9);
            if (mode <= 5) begin
                // random setup; to order 3 full pass + 0-3 done beats, else part
                if (ord <= 3) len = (4 ** (ord + 1)) + $urandom_range(0, 3);
                else          len = $urandom_range(10, 60);
                offer_item(1'b1);
                repeat (len - 1) offer_item(1'b0);
            end else if (mode == 6) begin
                // continue the pass left over from the previous setting
                len = $urandom_range(5, 40);
                repeat (len) offer_item(1'b0);
            end else begin
                // broken sequences: restarts at random points
                len = $urandom_range(5, 30);
                repeat (len) offer_item($urandom_range(0, 7) == 0);
            end
        end

        wait_for_results();
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
